### rtl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg: shared types and constants of the UTF-8 string validator
// Field widths, register indexes, decode masks and code point bounds.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  // Field and register widths.
  localparam int LEN_W   = 15;
  localparam int CP_W    = 21;
  localparam int CFG_IDX_W = 1;

  // Largest supported string length; the configured limit is clamped to it.
  localparam logic [LEN_W-1:0] MAX_STRING_BYTES = 15'd16384;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 15'd16384;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_CONTROLS = 1'b1;

  // Byte classes.
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] DEL_BYTE   = 8'h7F;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  // Sequence lengths.
  localparam logic [2:0] SEQ_NONE  = 3'd0;
  localparam logic [2:0] SEQ_TWO   = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR  = 3'd4;

  // Code point bounds.
  localparam logic [CP_W-1:0] MIN_CP2 = 21'h00080;
  localparam logic [CP_W-1:0] MIN_CP3 = 21'h00800;
  localparam logic [CP_W-1:0] MIN_CP4 = 21'h10000;
  localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h0DFFF;

  typedef struct packed {
    logic [LEN_W-1:0] max_length;
    logic             reject_controls;
  } cfg_t;

  typedef struct packed {
    logic             string_valid;
    logic [LEN_W-1:0] string_length;
  } verdict_t;

  typedef struct packed {
    logic     valid;
    verdict_t verdict;
  } result_t;

endpackage

### rtl/utf8v_byte_if.sv
// ----------------------------------------------------------------------------
// utf8v_byte_if: byte stream channel
// Valid/ready channel carrying one string byte and its end markers.
// ----------------------------------------------------------------------------
interface utf8v_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;
  logic       no_data;

  modport source (output valid, output data_byte, output end_of_string,
                  output no_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_string,
                  input no_data, output ready);
endinterface

### rtl/utf8v_verdict_if.sv
// ----------------------------------------------------------------------------
// utf8v_verdict_if: verdict channel
// Valid/ready channel carrying the verdict and length of one string.
// ----------------------------------------------------------------------------
interface utf8v_verdict_if;
  logic        valid;
  logic        ready;
  logic        string_valid;
  logic [14:0] string_length;

  modport source (output valid, output string_valid, output string_length,
                  input ready);
  modport sink   (input valid, input string_valid, input string_length,
                  output ready);
endinterface

### rtl/utf8v_decoder.sv
// ----------------------------------------------------------------------------
// utf8v_decoder: strict UTF-8 decode state and string verdict
// Updates the sequence state and byte count for each accepted transaction
// and forms the verdict when a string ends.
// ----------------------------------------------------------------------------
module utf8v_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              end_of_string,
  input  logic              no_data,
  input  utf8v_pkg::cfg_t   cfg,
  output utf8v_pkg::result_t result
);
  import utf8v_pkg::*;

  logic [1:0]       pending_count, pending_count_next;
  logic [2:0]       seq_length, seq_length_next;
  logic [CP_W-1:0]  code_accum, code_accum_next;
  logic             failed, failed_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] limit;

  // Effective limit: configured length clamped to the supported maximum.
  assign limit = (cfg.max_length > MAX_STRING_BYTES) ? MAX_STRING_BYTES : cfg.max_length;

  // Decode update for one byte, then the verdict on the updated state.
  always_comb begin
    logic             ctrl_bad;
    logic [CP_W-1:0]  cp;
    logic             cp_bad;
    logic [1:0]       p;
    logic [2:0]       s;
    logic [CP_W-1:0]  a;
    logic             f;
    logic [LEN_W-1:0] c;
    logic             done;

    p = pending_count;
    s = seq_length;
    a = code_accum;
    f = failed;
    c = byte_count;
    ctrl_bad = 1'b0;
    cp = {code_accum[CP_W-7:0], data_byte[5:0]};
    cp_bad = 1'b0;

    if (!no_data) begin
      if (byte_count <= limit) begin
        c = byte_count + 1'b1;
      end
      ctrl_bad = cfg.reject_controls && ((data_byte < CTRL_LIMIT) || (data_byte == DEL_BYTE));
      if (ctrl_bad) begin
        // A control byte is plain ASCII, so only the failure remains.
        f = 1'b1;
        p = 2'd0;
        s = SEQ_NONE;
        a = '0;
      end else if (pending_count == 2'd0) begin
        if (data_byte <= DEL_BYTE) begin
          // Single-byte character: state unchanged.
        end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
          s = SEQ_TWO;
          p = 2'd1;
          a = {{(CP_W-5){1'b0}}, data_byte[4:0]};
        end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
          s = SEQ_THREE;
          p = 2'd2;
          a = {{(CP_W-4){1'b0}}, data_byte[3:0]};
        end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
          s = SEQ_FOUR;
          p = 2'd3;
          a = {{(CP_W-3){1'b0}}, data_byte[2:0]};
        end else begin
          f = 1'b1;
          p = 2'd0;
          s = SEQ_NONE;
          a = '0;
        end
      end else if ((data_byte & CONT_MASK) != CONT_CODE) begin
        f = 1'b1;
        p = 2'd0;
        s = SEQ_NONE;
        a = '0;
      end else begin
        p = pending_count - 2'd1;
        if (p == 2'd0) begin
          // Sequence complete: check overlong forms, range and surrogates.
          cp_bad = ((seq_length == SEQ_TWO) && (cp < MIN_CP2))
                || ((seq_length == SEQ_THREE) && (cp < MIN_CP3))
                || ((seq_length == SEQ_FOUR) && (cp < MIN_CP4))
                || (cp > MAX_CP)
                || ((cp >= SURR_LO) && (cp <= SURR_HI));
          s = SEQ_NONE;
          a = '0;
          if (cp_bad) begin
            f = 1'b1;
          end
        end else begin
          a = cp;
        end
      end
    end

    done = no_data || end_of_string;

    result.valid = take && done;
    result.verdict.string_valid = !f && (p == 2'd0) && (c != '0) && (c <= limit);
    result.verdict.string_length = c;

    if (take && done) begin
      pending_count_next = 2'd0;
      seq_length_next = SEQ_NONE;
      code_accum_next = '0;
      failed_next = 1'b0;
      byte_count_next = '0;
    end else if (take) begin
      pending_count_next = p;
      seq_length_next = s;
      code_accum_next = a;
      failed_next = f;
      byte_count_next = c;
    end else begin
      pending_count_next = pending_count;
      seq_length_next = seq_length;
      code_accum_next = code_accum;
      failed_next = failed;
      byte_count_next = byte_count;
    end
  end

  // String state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      seq_length <= SEQ_NONE;
      code_accum <= '0;
      failed <= 1'b0;
      byte_count <= '0;
    end else begin
      pending_count <= pending_count_next;
      seq_length <= seq_length_next;
      code_accum <= code_accum_next;
      failed <= failed_next;
      byte_count <= byte_count_next;
    end
  end

`ifndef ASSERT_OFF
  // An open sequence is longer than the continuations still expected.
  assert property (@(posedge clk) disable iff (rst)
    (pending_count != 2'd0) |-> (seq_length > {1'b0, pending_count}))
    else $error("sequence length does not match pending count");

  // With no sequence open, the accumulator and length are cleared.
  assert property (@(posedge clk) disable iff (rst)
    (pending_count == 2'd0) |-> ((code_accum == '0) && (seq_length == SEQ_NONE)))
    else $error("stale sequence state with nothing pending");

  // A string end leaves the decoder cleared for the next string.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |=> ((byte_count == '0) && !failed && (pending_count == 2'd0)))
    else $error("string state not cleared after verdict");
`endif
endmodule

### rtl/utf8v_out_buf.sv
// ----------------------------------------------------------------------------
// utf8v_out_buf: two-entry verdict buffer
// Output register with a skid entry behind it, so the byte side keeps
// running while a verdict waits to be taken.
// ----------------------------------------------------------------------------
module utf8v_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utf8v_pkg::verdict_t din,
  output logic                full,
  output logic                valid,
  output utf8v_pkg::verdict_t dout,
  input  logic                pop_ready
);
  import utf8v_pkg::*;

  logic [1:0] count;
  verdict_t   slot0;
  verdict_t   slot1;
  logic       pop;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = slot0;
  assign pop   = valid && pop_ready;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Payload entries; slot0 is the one presented to the sink.
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= din;
      end else begin
        slot0 <= slot1;
        slot1 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

`ifndef ASSERT_OFF
  // No verdict arrives while both entries are occupied.
  assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("verdict pushed into a full buffer");

  // Draining one of two entries still leaves a verdict on the output.
  assert property (@(posedge clk) disable iff (rst)
    (full && pop) |=> valid)
    else $error("skid entry lost on pop");
`endif
endmodule

### rtl/utf8_string_validator_core.sv
// ----------------------------------------------------------------------------
// utf8_string_validator_core: strict UTF-8 string validator
// Checks a byte stream against strict UTF-8 and a length limit and gives
// one verdict per string.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the verdict buffer has room; the decode
// update is combinational from the string state registers to the verdict buffer,
// which registers the verdict when the last byte (or empty-string marker) of a
// string is accepted and presents it once any verdicts ahead of it are taken.
// Reset: clears the string state and sets max_length to 16384 and
// reject_controls to 0; the block is ready as soon as reset ends.
module utf8_string_validator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [utf8v_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [utf8v_pkg::LEN_W-1:0]            cfg_data,
  utf8v_byte_if.sink                            byte_stream,
  utf8v_verdict_if.source                       verdict
);
  import utf8v_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    buf_full;
  logic    buf_valid;
  verdict_t buf_dout;
  logic    take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length <= MAX_LENGTH_RESET;
      cfg.reject_controls <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LENGTH:      cfg.max_length <= cfg_data;
        CFG_REJECT_CONTROLS: cfg.reject_controls <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Byte side handshake: stall only when both verdict entries are taken.
  assign byte_stream.ready = !buf_full;
  assign take = byte_stream.valid && byte_stream.ready;

  utf8v_decoder u_decoder (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (byte_stream.data_byte),
    .end_of_string (byte_stream.end_of_string),
    .no_data       (byte_stream.no_data),
    .cfg           (cfg),
    .result        (result)
  );

  utf8v_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (result.valid),
    .din       (result.verdict),
    .full      (buf_full),
    .valid     (buf_valid),
    .dout      (buf_dout),
    .pop_ready (verdict.ready)
  );

  assign verdict.valid         = buf_valid;
  assign verdict.string_valid  = buf_dout.string_valid;
  assign verdict.string_length = buf_dout.string_length;

`ifndef ASSERT_OFF
  // The byte side stalls only while verdicts are waiting.
  assert property (@(posedge clk) disable iff (rst)
    !byte_stream.ready |-> verdict.valid)
    else $error("byte stream stalled with no verdict pending");

  // An accepted string end shows a verdict in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (take && (byte_stream.no_data || byte_stream.end_of_string)) |=> verdict.valid)
    else $error("string end produced no verdict");
`endif
endmodule

### sim/utf8_string_validator_core_test.sv
// ----------------------------------------------------------------------------
// utf8_string_validator_core_test: testbench of the UTF-8 string validator
// Streams directed and random byte strings through the validator under
// several length limits, control byte modes and flow control patterns, and
// checks every verdict against a cycle-free predictor of the decoder.
// ----------------------------------------------------------------------------
module utf8_string_validator_core_test;
  import utf8v_pkg::*;

  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Random stimulus: phases and byte transactions per phase.
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 110;
  // Ways a random string is closed.
  localparam int END_EMPTY = 0;
  localparam int END_MARKER = 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0] cfg_data;

  utf8v_byte_if byte_ch ();
  utf8v_verdict_if verdict_ch ();

  utf8_string_validator_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_stream(byte_ch),
    .verdict    (verdict_ch)
  );

  always #6 clk = ~clk;

  // Flow control pressure, changed per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Predictor copy of the registers and the per-string decode state.
  logic [LEN_W-1:0] cfg_max_len = MAX_LENGTH_RESET;
  logic cfg_reject = 1'b0;
  logic [1:0] sp_pending = '0;
  logic [2:0] sp_seq = SEQ_NONE;
  logic [CP_W-1:0] sp_code = '0;
  logic sp_failed = 1'b0;
  logic [LEN_W-1:0] sp_count = '0;

  verdict_t expected_verdicts[$];
  verdict_t popped_verdict;
  logic [7:0] str_bytes[$];
  int fail_count = 0;

  // A failed check drops any open sequence; the string stays invalid.
  function automatic void drop_sequence();
    sp_failed = 1'b1;
    sp_pending = '0;
    sp_seq = SEQ_NONE;
    sp_code = '0;
  endfunction

  // Advance the decoder by one byte transaction and form the verdict when
  // the string closes.
  task automatic predict_item(input logic [7:0] b, input logic eos, input logic nod,
                              output logic has_verdict, output verdict_t v);
    logic [LEN_W:0] lim;
    logic [CP_W-1:0] cp;
    logic bad;
    lim = (cfg_max_len > MAX_STRING_BYTES) ? {1'b0, MAX_STRING_BYTES} : {1'b0, cfg_max_len};
    has_verdict = 1'b0;
    v = '0;
    if (!nod) begin
      if ({1'b0, sp_count} < lim + 1'b1) sp_count = sp_count + 1'b1;
      if (cfg_reject && (b < CTRL_LIMIT || b == DEL_BYTE)) drop_sequence();
      if (sp_pending == 2'd0) begin
        // Lead byte or plain ASCII.
        if (!b[7]) begin
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          sp_seq = SEQ_TWO;
          sp_pending = 2'd1;
          sp_code = {16'd0, b[4:0]};
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          sp_seq = SEQ_THREE;
          sp_pending = 2'd2;
          sp_code = {17'd0, b[3:0]};
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
          sp_seq = SEQ_FOUR;
          sp_pending = 2'd3;
          sp_code = {18'd0, b[2:0]};
        end else begin
          drop_sequence();
        end
      end else if ((b & CONT_MASK) != CONT_CODE) begin
        drop_sequence();
      end else begin
        // Continuation byte; check the finished code point.
        sp_code = {sp_code[CP_W-7:0], b[5:0]};
        sp_pending = sp_pending - 2'd1;
        if (sp_pending == 2'd0) begin
          cp = sp_code;
          bad = (sp_seq == SEQ_TWO && cp < MIN_CP2) || (sp_seq == SEQ_THREE && cp < MIN_CP3)
                || (sp_seq == SEQ_FOUR && cp < MIN_CP4) || cp > MAX_CP
                || (cp >= SURR_LO && cp <= SURR_HI);
          sp_seq = SEQ_NONE;
          sp_code = '0;
          if (bad) drop_sequence();
        end
      end
    end
    if (nod || eos) begin
      has_verdict = 1'b1;
      v.string_valid = !sp_failed && sp_pending == 2'd0 && sp_count != '0
                       && {1'b0, sp_count} <= lim;
      v.string_length = sp_count;
      sp_pending = '0;
      sp_seq = SEQ_NONE;
      sp_code = '0;
      sp_failed = 1'b0;
      sp_count = '0;
    end
  endtask

  // Send one byte transaction; called and returning just after a falling edge.
  task automatic send_item(input logic [7:0] b, input logic eos, input logic nod);
    logic has_verdict;
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid = 1'b1;
    byte_ch.data_byte = b;
    byte_ch.end_of_string = eos;
    byte_ch.no_data = nod;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predict_item(b, eos, nod, has_verdict, v);
    if (has_verdict) expected_verdicts.push_back(v);
    @(negedge clk);
  endtask

  // Send up to twelve bytes from the low n bytes of seq, first byte highest.
  task automatic send_bytes(input logic [95:0] seq, input int n, input logic close);
    for (int i = n - 1; i >= 0; i--) send_item(seq[8*i +: 8], close && i == 0, 1'b0);
  endtask

  // Encode a code point with the given byte count, overlong forms included.
  task automatic append_cp(input logic [CP_W-1:0] cp, input int nb);
    case (nb)
      1: str_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Stop sending and let every pending verdict drain, plus a short tail.
  task automatic wait_idle();
    byte_ch.valid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == CFG_MAX_LENGTH) cfg_max_len = data;
    else cfg_reject = data[0];
    @(negedge clk);
  endtask

  // Both registers are rewritten only once the block has gone idle.
  task automatic configure(input logic [LEN_W-1:0] max_len, input logic reject);
    wait_idle();
    write_register(CFG_MAX_LENGTH, max_len);
    write_register(CFG_REJECT_CONTROLS, {{(LEN_W-1){1'b0}}, reject});
    cfg_we = 1'b0;
  endtask

  // Well-formed 1 to 4 byte characters under the reset settings.
  task automatic test_valid_sequences();
    send_bytes(96'h7F_C3A9_E282AC_F48FBFBF, 10, 1'b1);
    // Empty string marker.
    send_item(8'hA5, 1'b0, 1'b1);
  endtask

  // Overlong, surrogate, out of range, stray and truncated sequences.
  task automatic test_malformed();
    send_bytes(96'hE08080, 3, 1'b1);
    send_bytes(96'hEDA080, 3, 1'b1);
    send_bytes(96'hF4908080, 4, 1'b1);
    send_bytes(96'h80, 1, 1'b1);
    send_bytes(96'hF8, 1, 1'b1);
    // Open sequence closed by a no-data transaction.
    send_bytes(96'hE282, 2, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // Open sequence closed by the end-of-string flag.
    send_bytes(96'hC3, 1, 1'b1);
  endtask

  task automatic test_control_reject();
    configure(MAX_LENGTH_RESET, 1'b1);
    send_bytes(96'h1F, 1, 1'b1);
    send_bytes(96'h7F, 1, 1'b1);
  endtask

  // A zero limit makes any non-empty string too long and saturates at one.
  task automatic test_zero_limit();
    configure('0, 1'b0);
    send_bytes(96'h41, 1, 1'b1);
    send_bytes(96'h4141, 2, 1'b1);
  endtask

  // A limit above the supported maximum is clamped to it.
  task automatic test_clamped_limit();
    int counts[2];
    counts[0] = 4;
    counts[1] = 24;
    configure({LEN_W{1'b1}}, 1'b0);
    foreach (counts[s]) begin
      for (int i = 0; i < counts[s]; i++) begin
        send_item(8'($urandom_range(8'h21, 8'h7E)), i == counts[s] - 1, 1'b0);
      end
    end
  endtask

  // Random strings, mostly well formed, across settings and idle patterns.
  task automatic test_random_strings();
    int sent;
    int n_chars;
    int end_kind;
    int k;
    int nb;
    logic noisy;
    logic [CP_W-1:0] cp;
    logic [LEN_W-1:0] max_len;
    logic reject;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin max_len = 15'd16384; reject = 1'b0; end
        1: begin max_len = 15'd8;     reject = 1'b1; end
        2: begin max_len = 15'd1;     reject = 1'b0; end
        3: begin max_len = 15'd0;     reject = 1'b1; end
        4: begin max_len = 15'd32767; reject = 1'b0; end
        5: begin max_len = 15'd12;    reject = 1'b0; end
        6: begin max_len = 15'd3;     reject = 1'b1; end
        default: begin max_len = 15'd20; reject = 1'b1; end
      endcase
      configure(max_len, reject);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Build one string of random characters.
        str_bytes.delete();
        noisy = ($urandom_range(9) < 3);
        n_chars = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
        repeat (n_chars) begin
          if (noisy && $urandom_range(3) == 0) begin
            case ($urandom_range(4))
              0: str_bytes.push_back(8'($urandom));
              1: begin
                // Overlong form, sometimes just below the boundary.
                nb = $urandom_range(2, 4);
                if ($urandom_range(1) == 0) cp = 21'($urandom_range(0, 127));
                else cp = (nb == 2) ? 21'h7F : (nb == 3) ? 21'h7FF : 21'hFFFF;
                append_cp(cp, nb);
              end
              2: append_cp(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
              3: append_cp(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
              default: begin
                // Truncated sequence.
                append_cp(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
                repeat ($urandom_range(1, 3)) str_bytes.delete(str_bytes.size() - 1);
              end
            endcase
          end else begin
            k = $urandom_range(9);
            if (k < 4) begin
              append_cp(21'($urandom_range(0, 127)), 1);
            end else if (k < 6) begin
              append_cp(21'($urandom_range(32'h80, 32'h7FF)), 2);
            end else if (k < 8) begin
              cp = 21'($urandom_range(32'h800, 32'hFFFF));
              if (cp >= SURR_LO && cp <= SURR_HI) cp = cp + 21'h800;
              append_cp(cp, 3);
            end else begin
              append_cp(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
            end
          end
        end
        // Close it on the last byte, by a marker, or send an empty string.
        end_kind = $urandom_range(9);
        if (end_kind == END_EMPTY) begin
          send_item(8'($urandom), 1'($urandom), 1'b1);
          sent++;
        end else begin
          foreach (str_bytes[i]) begin
            send_item(str_bytes[i], end_kind != END_MARKER && i == str_bytes.size() - 1, 1'b0);
          end
          sent += str_bytes.size();
          if (end_kind == END_MARKER) begin
            send_item(8'($urandom), 1'($urandom), 1'b1);
            sent++;
          end
        end
      end
    end
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    verdict_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each verdict transaction with the oldest predicted verdict.
  always @(posedge clk) begin
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected verdict: valid %0b length %0d",
                   verdict_ch.string_valid, verdict_ch.string_length);
        end
      end else begin
        popped_verdict = expected_verdicts.pop_front();
        if (verdict_ch.string_valid !== popped_verdict.string_valid
            || verdict_ch.string_length !== popped_verdict.string_length) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("verdict mismatch: expected valid %0b length %0d, got valid %0b length %0d",
                     popped_verdict.string_valid, popped_verdict.string_length,
                     verdict_ch.string_valid, verdict_ch.string_length);
          end
        end
      end
    end
  end

  // Hang detection: too many cycles in a row without any transaction.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.end_of_string = 1'b0;
    byte_ch.no_data = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_LENGTH;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_valid_sequences();
    test_malformed();
    test_control_reject();
    test_zero_limit();
    test_clamped_limit();
    test_random_strings();
    wait_idle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
